[hw/rtl/backlight_timeout_dimmer_core_macros.svh]
`ifndef BACKLIGHT_TIMEOUT_DIMMER_CORE_MACROS_SVH
`define BACKLIGHT_TIMEOUT_DIMMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BLTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BLTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bltd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bltd_pkg;

	localparam int PwmBits   = 8;
	localparam int CmdW      = 3;
	localparam int ModeW     = 3;
	localparam int PctW      = 7;
	localparam int TimeW     = 32;
	localparam int TimeoutW  = 16;
	localparam int DivW      = 4;
	localparam int DutyW     = 9;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;

	localparam int PctMax       = 100;
	localparam int ResetTimeout = 10;
	localparam int ResetLow     = 10;
	localparam int ResetHigh    = 70;
	localparam int ResetDiv     = 10;
	localparam int ResetPercent = 70;

	localparam int PctEntries = 2 ** PctW;
	localparam int ModEntries = 2 ** (2 * DivW);

	typedef enum logic [CmdW-1:0] {
		CMD_SET_MODE    = 3'd0,
		CMD_SET_PERCENT = 3'd1,
		CMD_TRIGGER     = 3'd2,
		CMD_TOUCH       = 3'd3,
		CMD_TICK        = 3'd4
	} cmd_t;

	typedef enum logic [ModeW-1:0] {
		MODE_NONE     = 3'd0,
		MODE_ON       = 3'd1,
		MODE_TEMP_ON  = 3'd2,
		MODE_TEMP_OFF = 3'd3,
		MODE_DIMMING  = 3'd4
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TIMEOUT = 2'd0,
		REG_LOW     = 2'd1,
		REG_HIGH    = 2'd2,
		REG_DIV     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic [ModeW-1:0] new_mode;
		logic [PctW-1:0]  value_percent;
		logic [TimeW-1:0] timestamp;
	} item_t;

	typedef struct packed {
		logic [TimeoutW-1:0] timeout_seconds;
		logic [PctW-1:0]     low_percent;
		logic [PctW-1:0]     high_percent;
		logic [DivW-1:0]     dim_divisor;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [PctW-1:0]   percent;
		logic [DutyW-1:0]  duty;
		logic [TimeW-1:0]  trigger_time;
		logic [DivW-1:0]   dim_count;
	} state_t;

	typedef logic [DutyW-1:0] duty_table_t [PctEntries];
	typedef logic [DivW-1:0]  mod_table_t  [ModEntries];

	// duty = pct * 2^PwmBits / 100, kept to the output width
	function automatic duty_table_t gen_duty_table();
		duty_table_t t;
		for (int i = 0; i < PctEntries; i++) begin
			t[i] = DutyW'((i << PwmBits) / PctMax);
		end
		return t;
	endfunction

	// index {count, divisor}: (count + 1) mod divisor, divisor zero acts as one
	function automatic mod_table_t gen_mod_table();
		mod_table_t t;
		int         c;
		int         d;
		int         r;
		for (int i = 0; i < ModEntries; i++) begin
			c = i >> DivW;
			d = i & ((1 << DivW) - 1);
			if (d == 0) begin
				d = 1;
			end
			r = c + 1;
			while (r >= d) begin
				r = r - d;
			end
			t[i] = DivW'(r);
		end
		return t;
	endfunction

	localparam duty_table_t DutyTable = gen_duty_table();
	localparam mod_table_t  ModTable  = gen_mod_table();

	function automatic logic [PctW-1:0] sat_pct(input logic [PctW-1:0] p);
		return (p > PctW'(PctMax)) ? PctW'(PctMax) : p;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/bltd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bltd_req_if import bltd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CmdW-1:0]  command;
	logic [ModeW-1:0] new_mode;
	logic [PctW-1:0]  value_percent;
	logic [TimeW-1:0] timestamp;

	modport source (output valid, command, new_mode, value_percent, timestamp, input ready);
	modport sink (input valid, command, new_mode, value_percent, timestamp, output ready);
endinterface

interface bltd_rsp_if import bltd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DutyW-1:0] duty;
	logic [ModeW-1:0] mode;
	logic [PctW-1:0]  percent_now;

	modport source (output valid, duty, mode, percent_now, input ready);
	modport sink (input valid, duty, mode, percent_now, output ready);
endinterface

`default_nettype wire

[hw/rtl/bltd_next.sv]
`timescale 1ns / 1ps
`default_nettype none

module bltd_next import bltd_pkg::*; (
	input  item_t  item,
	input  cfg_t   cfg,
	input  state_t cur,
	output state_t nxt
);

	logic [TimeW:0]    deadline;
	logic              timed_out;
	logic              dimming;
	logic [DivW-1:0]   count_base;
	logic [DivW-1:0]   count_new;
	logic [PctW-1:0]   pct_dimmed;
	logic [PctW-1:0]   high_sat;

	assign high_sat  = sat_pct(cfg.high_percent);
	assign deadline  = {1'b0, cur.trigger_time} + (TimeW+1)'(cfg.timeout_seconds);
	assign timed_out = (cur.mode == MODE_TEMP_ON) && (deadline < {1'b0, item.timestamp});
	assign dimming   = timed_out || (cur.mode == MODE_DIMMING);
	// a timeout restarts the dim count
	assign count_base = timed_out ? '0 : cur.dim_count;
	assign count_new  = ModTable[{count_base, cfg.dim_divisor}];
	assign pct_dimmed = (count_new == '0) ? (cur.percent - PctW'(1)) : cur.percent;

	always_comb begin
		nxt = cur;
		unique case (item.command)
			CMD_SET_MODE: begin
				if (item.new_mode <= MODE_DIMMING) begin
					nxt.mode = mode_t'(item.new_mode);
					if (item.new_mode == MODE_ON || item.new_mode == MODE_TEMP_ON) begin
						nxt.duty = DutyTable[cur.percent];
					end else if (item.new_mode == MODE_NONE
							|| item.new_mode == MODE_TEMP_OFF) begin
						nxt.duty = '0;
					end
					if (item.new_mode == MODE_TEMP_ON || item.new_mode == MODE_TEMP_OFF) begin
						nxt.trigger_time = item.timestamp;
					end
				end
			end
			CMD_SET_PERCENT: begin
				nxt.percent = sat_pct(item.value_percent);
			end
			CMD_TRIGGER: begin
				if (cur.mode == MODE_TEMP_OFF) begin
					nxt.mode         = MODE_TEMP_ON;
					nxt.trigger_time = item.timestamp;
					nxt.duty         = DutyTable[cur.percent];
				end else if (cur.mode == MODE_TEMP_ON) begin
					nxt.trigger_time = item.timestamp;
				end
			end
			CMD_TOUCH: begin
				nxt.trigger_time = item.timestamp;
				if (cur.mode == MODE_TEMP_OFF || cur.mode == MODE_DIMMING
						|| cur.mode == MODE_TEMP_ON) begin
					nxt.mode    = MODE_TEMP_ON;
					nxt.percent = high_sat;
					nxt.duty    = DutyTable[high_sat];
				end
			end
			CMD_TICK: begin
				if (timed_out) begin
					nxt.duty         = '0;
					nxt.mode         = MODE_DIMMING;
					nxt.trigger_time = '0;
					nxt.dim_count    = '0;
				end
				if (dimming) begin
					if (cur.percent <= cfg.low_percent) begin
						nxt.mode = MODE_TEMP_OFF;
					end else begin
						nxt.dim_count = count_new;
						nxt.percent   = pct_dimmed;
						nxt.duty      = DutyTable[pct_dimmed];
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/backlight_timeout_dimmer_core.sv]
// Results: an accepted command transaction is held in the input stage register and moves
// into the result register once that register is free or being taken by the receiver.
// Throughput: one command per cycle while the receiver takes results; the mode update is
// combinational between the input stage register and the result register.
// Reset (arst_n low): mode none, 70 percent, duty 0, trigger time 0, dim count 0,
// registers back to timeout 10, low 10, high 70, divisor 10; no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "backlight_timeout_dimmer_core_macros.svh"

module backlight_timeout_dimmer_core import bltd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	bltd_req_if.sink                 req,
	bltd_rsp_if.source               rsp
);

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;
	item_t  item_s1;
	item_t  req_item;
	logic   valid_s1;
	logic   advance;
	logic   req_fire;

	logic             rsp_valid_q;
	logic [DutyW-1:0] rsp_duty_q;
	logic [ModeW-1:0] rsp_mode_q;
	logic [PctW-1:0]  rsp_percent_q;

	assign req_item = '{
		command:       req.command,
		new_mode:      req.new_mode,
		value_percent: req.value_percent,
		timestamp:     req.timestamp
	};

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_seconds <= TimeoutW'(ResetTimeout);
			cfg_q.low_percent     <= PctW'(ResetLow);
			cfg_q.high_percent    <= PctW'(ResetHigh);
			cfg_q.dim_divisor     <= DivW'(ResetDiv);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TIMEOUT: cfg_q.timeout_seconds <= cfg_data[TimeoutW-1:0];
				REG_LOW:     cfg_q.low_percent     <= cfg_data[PctW-1:0];
				REG_HIGH:    cfg_q.high_percent    <= cfg_data[PctW-1:0];
				REG_DIV:     cfg_q.dim_divisor     <= cfg_data[DivW-1:0];
			endcase
		end
	end

	// input stage: hold the transaction until the result register can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1 <= req_item;
		end
	end

	bltd_next u_next (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= MODE_NONE;
			state_q.percent      <= PctW'(ResetPercent);
			state_q.duty         <= '0;
			state_q.trigger_time <= '0;
			state_q.dim_count    <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_duty_q    <= state_next.duty;
			rsp_mode_q    <= state_next.mode;
			rsp_percent_q <= state_next.percent;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.duty        = rsp_duty_q;
	assign rsp.mode        = rsp_mode_q;
	assign rsp.percent_now = rsp_percent_q;

	`BLTD_ASSERT_NOW(a_pct_range, 1'b1, state_q.percent <= PctW'(PctMax), "percent above 100")
	`BLTD_ASSERT_NEXT(a_adv_rsp, advance, rsp_valid_q, "result lost after advance")
	`BLTD_ASSERT_NEXT(a_stall_hold, valid_s1 && !advance, valid_s1 && $stable(state_q), "stalled transaction dropped or state moved")

endmodule

`default_nettype wire

[verif/tb_backlight_timeout_dimmer_core.sv]
`timescale 1ns / 1ps

module tb_backlight_timeout_dimmer_core;
	import bltd_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int PhaseCount = 12;
	localparam int PhaseItems = 150;
	localparam int DirCount   = 26;
	localparam int ReportCap  = 40;

	// command and mode codes outside the legal range
	localparam logic [CmdW-1:0]  CMD_BAD_LO = 3'd5;
	localparam logic [CmdW-1:0]  CMD_BAD_HI = 3'd7;
	localparam logic [ModeW-1:0] MODE_BAD   = 3'd7;

	typedef struct packed {
		logic [DutyW-1:0] duty;
		logic [ModeW-1:0] mode;
		logic [PctW-1:0]  pct;
	} lamp_view_t;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [ModeW-1:0] nm;
		logic [PctW-1:0]  vp;
		logic [TimeW-1:0] ts;
		logic             typed;
		lamp_view_t       view;
	} dir_row_t;

	// Rows run under the reset register values: timeout 10, low 10, high 70, divisor 10.
	localparam dir_row_t DirRows [DirCount] = '{
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'd0,          1'b1,
			'{9'd0,   MODE_NONE,    7'd70}},
		'{CMD_SET_PERCENT, MODE_NONE,    7'd127, 32'd0,          1'b1,
			'{9'd0,   MODE_NONE,    7'd100}},
		'{CMD_SET_MODE,    MODE_ON,      7'd0,   32'd0,          1'b1,
			'{9'd256, MODE_ON,      7'd100}},
		'{CMD_SET_PERCENT, MODE_NONE,    7'd0,   32'd0,          1'b1,
			'{9'd256, MODE_ON,      7'd0}},
		'{CMD_SET_MODE,    MODE_ON,      7'd0,   32'd0,          1'b1,
			'{9'd0,   MODE_ON,      7'd0}},
		'{CMD_SET_MODE,    MODE_BAD,     7'd0,   32'd0,          1'b1,
			'{9'd0,   MODE_ON,      7'd0}},
		'{CMD_BAD_LO,      MODE_NONE,    7'd0,   32'hFFFF_FFFF,  1'b1,
			'{9'd0,   MODE_ON,      7'd0}},
		'{CMD_BAD_HI,      MODE_BAD,     7'd127, 32'hFFFF_FFFF,  1'b1,
			'{9'd0,   MODE_ON,      7'd0}},
		'{CMD_TOUCH,       MODE_NONE,    7'd0,   32'd5,          1'b1,
			'{9'd0,   MODE_ON,      7'd0}},
		'{CMD_TRIGGER,     MODE_NONE,    7'd0,   32'd6,          1'b1,
			'{9'd0,   MODE_ON,      7'd0}},
		'{CMD_SET_PERCENT, MODE_NONE,    7'd50,  32'd0,          1'b0, '0},
		'{CMD_SET_MODE,    MODE_TEMP_ON, 7'd0,   32'd100,        1'b0, '0},
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'd110,        1'b0, '0},
		'{CMD_TRIGGER,     MODE_NONE,    7'd0,   32'd105,        1'b0, '0},
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'd116,        1'b0, '0},
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'd117,        1'b0, '0},
		'{CMD_TOUCH,       MODE_NONE,    7'd0,   32'd120,        1'b0, '0},
		'{CMD_SET_MODE,    MODE_TEMP_OFF, 7'd0,  32'd130,        1'b0, '0},
		'{CMD_TRIGGER,     MODE_NONE,    7'd0,   32'd140,        1'b0, '0},
		'{CMD_SET_PERCENT, MODE_NONE,    7'd5,   32'd0,          1'b0, '0},
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'd200,        1'b0, '0},
		'{CMD_SET_MODE,    MODE_DIMMING, 7'd0,   32'd0,          1'b0, '0},
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'd201,        1'b0, '0},
		'{CMD_SET_MODE,    MODE_TEMP_ON, 7'd0,   32'hFFFF_FFFA,  1'b0, '0},
		'{CMD_TICK,        MODE_NONE,    7'd0,   32'hFFFF_FFFF,  1'b0, '0},
		'{CMD_SET_MODE,    MODE_NONE,    7'd0,   32'd0,          1'b0, '0}
	};

	// extreme register settings for the first phases: timeout, low, high, divisor
	localparam logic [TimeoutW-1:0] FixTimeout [4] = '{16'd0, 16'd65535, 16'd3, 16'd1};
	localparam logic [PctW-1:0]     FixLow     [4] = '{7'd0, 7'd100, 7'd127, 7'd20};
	localparam logic [PctW-1:0]     FixHigh    [4] = '{7'd100, 7'd127, 7'd0, 7'd60};
	localparam logic [DivW-1:0]     FixDiv     [4] = '{4'd1, 4'd15, 4'd0, 4'd2};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	bltd_req_if req_ch ();
	bltd_rsp_if rsp_ch ();

	backlight_timeout_dimmer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predicted block state and register copy
	mode_t               bl_mode;
	logic [PctW-1:0]     bl_pct;
	logic [DutyW-1:0]    bl_duty;
	logic [TimeW-1:0]    bl_trig;
	logic [DivW-1:0]     bl_count;
	logic [TimeoutW-1:0] cfg_timeout;
	logic [PctW-1:0]     cfg_low;
	logic [PctW-1:0]     cfg_high;
	logic [DivW-1:0]     cfg_div;

	lamp_view_t  lamp_expected [$];
	logic [31:0] clock_secs;
	bit          steady;
	int          cycle_count;
	int          errors;
	int          commands_sent;
	int          results_checked;
	int          dim_results;
	int          settings_used;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic [DutyW-1:0] duty_for(input logic [PctW-1:0] pct);
		return DutyW'((int'(pct) * (1 << PwmBits)) / PctMax);
	endfunction

	function automatic logic [PctW-1:0] clamp_pct(input logic [PctW-1:0] pct);
		return (int'(pct) > PctMax) ? PctW'(PctMax) : pct;
	endfunction

	// advance the predicted state by one command and return the visible outputs
	function automatic lamp_view_t step_backlight(input item_t it);
		logic [TimeW:0] deadline;
		int             div;
		lamp_view_t     v;
		case (it.command)
			CMD_SET_MODE: begin
				if (it.new_mode <= MODE_DIMMING) begin
					bl_mode = mode_t'(it.new_mode);
					if (bl_mode == MODE_ON || bl_mode == MODE_TEMP_ON) begin
						bl_duty = duty_for(bl_pct);
					end else if (bl_mode == MODE_NONE || bl_mode == MODE_TEMP_OFF) begin
						bl_duty = '0;
					end
					if (bl_mode == MODE_TEMP_ON || bl_mode == MODE_TEMP_OFF) begin
						bl_trig = it.timestamp;
					end
				end
			end
			CMD_SET_PERCENT: begin
				bl_pct = clamp_pct(it.value_percent);
			end
			CMD_TRIGGER: begin
				if (bl_mode == MODE_TEMP_OFF) begin
					bl_mode = MODE_TEMP_ON;
					bl_trig = it.timestamp;
					bl_duty = duty_for(bl_pct);
				end else if (bl_mode == MODE_TEMP_ON) begin
					bl_trig = it.timestamp;
				end
			end
			CMD_TOUCH: begin
				bl_trig = it.timestamp;
				if (bl_mode == MODE_TEMP_OFF || bl_mode == MODE_DIMMING) begin
					bl_mode = MODE_TEMP_ON;
				end
				if (bl_mode == MODE_TEMP_ON) begin
					bl_pct  = clamp_pct(cfg_high);
					bl_duty = duty_for(bl_pct);
				end
			end
			CMD_TICK: begin
				// the deadline sum is one bit wider so it never wraps
				deadline = {1'b0, bl_trig} + (TimeW + 1)'(cfg_timeout);
				if (bl_mode == MODE_TEMP_ON && deadline < {1'b0, it.timestamp}) begin
					bl_duty  = '0;
					bl_mode  = MODE_DIMMING;
					bl_trig  = '0;
					bl_count = '0;
				end
				if (bl_mode == MODE_DIMMING) begin
					if (bl_pct <= cfg_low) begin
						bl_mode = MODE_TEMP_OFF;
					end else begin
						div      = (cfg_div == 0) ? 1 : int'(cfg_div);
						bl_count = DivW'((int'(bl_count) + 1) % div);
						if (bl_count == 0) begin
							bl_pct = bl_pct - 1'b1;
						end
						bl_duty = duty_for(bl_pct);
					end
				end
			end
			default: begin
			end
		endcase
		v.duty = bl_duty;
		v.mode = bl_mode;
		v.pct  = bl_pct;
		return v;
	endfunction

	// mostly ticks with slowly advancing time, plus re-arms, touches and noise
	function automatic item_t pick_command();
		item_t it;
		int    r;
		it.new_mode      = ModeW'($urandom_range(0, 7));
		it.value_percent = PctW'($urandom_range(0, 127));
		it.timestamp     = clock_secs;
		r                = $urandom_range(0, 99);
		if (r < 50) begin
			it.command = CMD_TICK;
			if ($urandom_range(0, 9) == 0) begin
				// land right on or just past the deadline
				it.timestamp = bl_trig + TimeW'(cfg_timeout) + TimeW'($urandom_range(0, 1));
			end else begin
				clock_secs   = clock_secs + TimeW'($urandom_range(0, 2));
				it.timestamp = clock_secs;
			end
		end else if (r < 58) begin
			it.command = CMD_SET_MODE;
			if ($urandom_range(0, 1) == 0) begin
				it.new_mode = MODE_TEMP_ON;
			end
		end else if (r < 66) begin
			it.command = CMD_SET_PERCENT;
			if ($urandom_range(0, 3) == 0) begin
				it.value_percent = PctW'($urandom_range(96, 127));
			end
		end else if (r < 78) begin
			it.command = CMD_TRIGGER;
		end else if (r < 84) begin
			it.command = CMD_TOUCH;
		end else if (r < 87) begin
			it.command = CmdW'($urandom_range(int'(CMD_BAD_LO), int'(CMD_BAD_HI)));
		end else begin
			it.command  = CMD_SET_MODE;
			it.new_mode = ($urandom_range(0, 1) == 0) ? MODE_TEMP_OFF : MODE_DIMMING;
		end
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_command(input item_t it, input bit typed, input lamp_view_t typed_view);
		int         gap;
		lamp_view_t v;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.command       = it.command;
		req_ch.new_mode      = it.new_mode;
		req_ch.value_percent = it.value_percent;
		req_ch.timestamp     = it.timestamp;
		req_ch.valid         = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		v = step_backlight(it);
		lamp_expected.push_back(typed ? typed_view : v);
		commands_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (lamp_expected.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_setting(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		case (idx)
			REG_TIMEOUT: cfg_timeout = val[TimeoutW-1:0];
			REG_LOW:     cfg_low     = val[PctW-1:0];
			REG_HIGH:    cfg_high    = val[PctW-1:0];
			REG_DIV:     cfg_div     = val[DivW-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input logic [TimeoutW-1:0] tmo, input logic [PctW-1:0] lo,
			input logic [PctW-1:0] hi, input logic [DivW-1:0] dv);
		wait_drained();
		repeat (3) @(negedge clk);
		write_setting(REG_TIMEOUT, CfgDataW'(tmo));
		write_setting(REG_LOW, CfgDataW'(lo));
		write_setting(REG_HIGH, CfgDataW'(hi));
		write_setting(REG_DIV, CfgDataW'(dv));
		cfg_we = 1'b0;
		settings_used++;
	endtask

	// receiver: runs of ready mixed with short and occasional long stalls
	initial begin : drive_ready
		int hold_left;
		int r;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady) begin
				rsp_ch.ready = 1'b1;
				hold_left    = 0;
			end else if (hold_left > 0) begin
				hold_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					rsp_ch.ready = 1'b1;
					hold_left    = $urandom_range(0, 11);
				end else if (r < 90) begin
					rsp_ch.ready = 1'b0;
					hold_left    = $urandom_range(0, 2);
				end else begin
					rsp_ch.ready = 1'b0;
					hold_left    = $urandom_range(7, 29);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		lamp_view_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (lamp_expected.size() == 0) begin
				errors++;
				if (errors <= ReportCap) begin
					$display("%0t: result with nothing expected: duty %0d mode %0d pct %0d",
						$time, rsp_ch.duty, rsp_ch.mode, rsp_ch.percent_now);
				end
			end else begin
				want = lamp_expected.pop_front();
				results_checked++;
				if (rsp_ch.mode == MODE_DIMMING) begin
					dim_results++;
				end
				if (rsp_ch.duty !== want.duty) begin
					errors++;
					if (errors <= ReportCap) begin
						$display("%0t: duty mismatch: expected %0d, got %0d",
							$time, want.duty, rsp_ch.duty);
					end
				end
				if (rsp_ch.mode !== want.mode) begin
					errors++;
					if (errors <= ReportCap) begin
						$display("%0t: mode mismatch: expected %0d, got %0d",
							$time, want.mode, rsp_ch.mode);
					end
				end
				if (rsp_ch.percent_now !== want.pct) begin
					errors++;
					if (errors <= ReportCap) begin
						$display("%0t: percent mismatch: expected %0d, got %0d",
							$time, want.pct, rsp_ch.percent_now);
					end
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CycleLimit);
		$display("%0t: run timed out with %0d results outstanding", $time,
			lamp_expected.size());
		$display("tb_backlight_timeout_dimmer_core NOT OK");
		$finish;
	end

	initial begin : run_stimulus
		item_t it;
		lamp_view_t       none_view;
		logic [TimeoutW-1:0] tmo;
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_TIMEOUT;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.command       = CMD_SET_MODE;
		req_ch.new_mode      = MODE_NONE;
		req_ch.value_percent = '0;
		req_ch.timestamp     = '0;
		cycle_count          = 0;
		errors               = 0;
		commands_sent        = 0;
		results_checked      = 0;
		dim_results          = 0;
		settings_used        = 1;
		steady               = 1'b0;
		none_view            = '0;
		bl_mode              = MODE_NONE;
		bl_pct               = PctW'(ResetPercent);
		bl_duty              = '0;
		bl_trig              = '0;
		bl_count             = '0;
		cfg_timeout          = TimeoutW'(ResetTimeout);
		cfg_low              = PctW'(ResetLow);
		cfg_high             = PctW'(ResetHigh);
		cfg_div              = DivW'(ResetDiv);
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DirCount; i++) begin
			it.command       = DirRows[i].cmd;
			it.new_mode      = DirRows[i].nm;
			it.value_percent = DirRows[i].vp;
			it.timestamp     = DirRows[i].ts;
			send_command(it, DirRows[i].typed, DirRows[i].view);
		end

		for (int p = 0; p < PhaseCount; p++) begin
			if (p < 4) begin
				apply_settings(FixTimeout[p], FixLow[p], FixHigh[p], FixDiv[p]);
			end else begin
				tmo = ($urandom_range(0, 4) == 0) ? TimeoutW'($urandom_range(0, 65535))
					: TimeoutW'($urandom_range(0, 20));
				apply_settings(tmo, PctW'($urandom_range(0, 100)),
					PctW'($urandom_range(0, 127)), DivW'($urandom_range(0, 15)));
			end
			steady     = (p == 3 || p == 8);
			// one phase starts close to the top of the time range
			clock_secs = (p == 1) ? 32'hFFFF_FF00 : $urandom;
			for (int k = 0; k < PhaseItems; k++) begin
				if ($urandom_range(0, 99) == 0) begin
					wait_drained();
				end
				send_command(pick_command(), 1'b0, none_view);
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		$display("Covered %0d commands and %0d checked results over %0d register settings,",
			commands_sent, results_checked, settings_used);
		$display("with %0d results reporting the dimming mode.", dim_results);
		if (errors == 0) begin
			$display("tb_backlight_timeout_dimmer_core OK");
		end else begin
			$display("tb_backlight_timeout_dimmer_core NOT OK");
		end
		$finish;
	end

endmodule
